// ===== rtl/wlb_pkg.sv =====
// Shared types and constants of the weighted linear-binning histogram engine.
package wlb_pkg;

  localparam int unsigned MASS_W  = 56;
  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned FRAC_W  = 16;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    CFG_GRID_LOW      = 1'b0,
    CFG_INV_BIN_WIDTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_MUL,
    ST_POS,
    ST_AMT,
    ST_WA,
    ST_WB,
    ST_RLD,
    ST_DIV
  } state_t;

endpackage

// ===== rtl/weighted_linear_binning.sv =====
// Top level of the weighted linear-binning histogram engine.

// The engine keeps NBINS bin masses in one synchronous memory and a running
// total weight in a register. A command is taken when start is high and busy
// is low; configuration must be written by the user only while busy is low;
// the block does not enforce this. Operation is shaped by the read-modify-write
// of the bin memory through its one read and one write port and by the
// bit-serial divider: a clear (func 0) holds busy while it sweeps the memory
// one entry per cycle; a sample (func 1) holds busy through its steps (the
// subtract happens at the transfer, then 32x32 multiply, position decode,
// weight split, then one write per bin), so a new command is taken only once
// the sample is done; a read (func 2) gives its result from the registered
// memory read when the total weight is zero or the density saturates, and
// otherwise from the divider, one quotient bit per cycle. Func 3 is accepted
// and ignored. After reset the same clearing sweep runs with busy high before
// the first command. Each result is shown for exactly one cycle with out_valid
// high; the receiver cannot stall it, so it must take every result as it comes.
module weighted_linear_binning #(
  parameter int unsigned NBINS = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_sample_value,
  input  logic [15:0]        in_weight,
  input  logic [8:0]         in_bin_index,
  output logic               out_valid,
  output logic [31:0]        out_density,
  output logic               out_no_weight,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned AW = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int unsigned MW = wlb_pkg::MASS_W;
  localparam int unsigned TW = wlb_pkg::TOTAL_W;

  // Configuration registers.
  logic signed [31:0] grid_low_r;
  logic [31:0]        inv_bin_width_r;

  // Control state.
  wlb_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [4:0]      div_cnt_r, div_cnt_nxt;
  logic [TW-1:0]   total_r, total_nxt;

  // Sample datapath registers.
  logic [31:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [15:0]   w_r, w_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic          en_a_r, en_a_nxt, en_b_r, en_b_nxt;
  logic [AW-1:0] idx_a_r, idx_a_nxt, idx_b_r, idx_b_nxt;
  logic [16:0]   fac_a_r, fac_a_nxt, fac_b_r, fac_b_nxt;
  logic [32:0]   amt_a_r, amt_a_nxt, amt_b_r, amt_b_nxt;

  // Read and divide registers.
  logic          bin_ok_r, bin_ok_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [31:0]   dvd_r, dvd_nxt;
  logic [31:0]   quo_r, quo_nxt;

  // Result registers.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_density_r, out_density_nxt;
  logic        out_no_weight_r, out_no_weight_nxt;

  // Bin memory: one write and one read address per cycle, registered read.
  logic [MW-1:0] bin_mem [NBINS];
  logic [MW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;

  logic                accept;
  wlb_pkg::func_t      func_in;
  logic signed [32:0]  diff;
  logic [16:0]         bin_idx_ext;
  logic [64:0]         ceil_sum;
  logic [48:0]         q_neg;
  logic [31:0]         ix;
  logic [15:0]         fx;
  logic [MW-1:0]       mass_rd;
  logic [TW:0]         div_trial;
  logic                div_bit;

  function automatic logic [MW-1:0] sat_add(input logic [MW-1:0] a, input logic [32:0] b);
    logic [MW:0] sum;
    sum = {1'b0, a} + (MW+1)'(b);
    return sum[MW] ? {MW{1'b1}} : sum[MW-1:0];
  endfunction

  assign busy          = (state_r != wlb_pkg::ST_IDLE);
  assign accept        = start && !busy;
  assign func_in       = wlb_pkg::func_t'(in_func);
  assign out_valid     = out_valid_r;
  assign out_density   = out_density_r;
  assign out_no_weight = out_no_weight_r;

  // Position decode from the registered product.
  assign diff        = {in_sample_value[31], in_sample_value} - {grid_low_r[31], grid_low_r};
  assign bin_idx_ext = 17'(in_bin_index);
  assign ceil_sum    = {1'b0, prod_r} + 65'(16'hFFFF);
  assign q_neg       = ceil_sum[64:16];
  assign ix          = prod_r[63:32];
  assign fx          = prod_r[31:16];
  assign mass_rd     = bin_ok_r ? rd_data_r : '0;
  assign div_trial   = {rem_r, dvd_r[31]};
  assign div_bit     = (div_trial >= {1'b0, total_r});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wlb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func_in)
            wlb_pkg::FUNC_CLEAR: state_nxt = wlb_pkg::ST_CLR;
            wlb_pkg::FUNC_ADD:   state_nxt = wlb_pkg::ST_MUL;
            wlb_pkg::FUNC_READ:  state_nxt = wlb_pkg::ST_RLD;
            default:             state_nxt = wlb_pkg::ST_IDLE;
          endcase
        end
      end
      wlb_pkg::ST_CLR: begin
        if (clr_cnt_r == AW'(NBINS - 1)) state_nxt = wlb_pkg::ST_IDLE;
      end
      wlb_pkg::ST_MUL: state_nxt = wlb_pkg::ST_POS;
      wlb_pkg::ST_POS: state_nxt = wlb_pkg::ST_AMT;
      wlb_pkg::ST_AMT: state_nxt = wlb_pkg::ST_WA;
      wlb_pkg::ST_WA:  state_nxt = wlb_pkg::ST_WB;
      wlb_pkg::ST_WB:  state_nxt = wlb_pkg::ST_IDLE;
      wlb_pkg::ST_RLD: begin
        if (total_r != '0 && mass_rd < {total_r, 16'h0000}) state_nxt = wlb_pkg::ST_DIV;
        else state_nxt = wlb_pkg::ST_IDLE;
      end
      wlb_pkg::ST_DIV: begin
        if (div_cnt_r == '0) state_nxt = wlb_pkg::ST_IDLE;
      end
      default: state_nxt = wlb_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory control and results.
  always_comb begin
    clr_cnt_nxt       = clr_cnt_r;
    div_cnt_nxt       = div_cnt_r;
    total_nxt         = total_r;
    mag_nxt           = mag_r;
    neg_nxt           = neg_r;
    w_nxt             = w_r;
    prod_nxt          = prod_r;
    en_a_nxt          = en_a_r;
    en_b_nxt          = en_b_r;
    idx_a_nxt         = idx_a_r;
    idx_b_nxt         = idx_b_r;
    fac_a_nxt         = fac_a_r;
    fac_b_nxt         = fac_b_r;
    amt_a_nxt         = amt_a_r;
    amt_b_nxt         = amt_b_r;
    bin_ok_nxt        = bin_ok_r;
    rem_nxt           = rem_r;
    dvd_nxt           = dvd_r;
    quo_nxt           = quo_r;
    out_valid_nxt     = 1'b0;
    out_density_nxt   = out_density_r;
    out_no_weight_nxt = out_no_weight_r;
    mem_we            = 1'b0;
    mem_wa            = idx_a_r;
    mem_wd            = '0;
    mem_ra            = idx_a_r;

    unique case (state_r)
      wlb_pkg::ST_IDLE: begin
        mem_ra = bin_idx_ext[AW-1:0];
        if (accept) begin
          unique case (func_in)
            wlb_pkg::FUNC_CLEAR: begin
              total_nxt   = '0;
              clr_cnt_nxt = '0;
            end
            wlb_pkg::FUNC_ADD: begin
              // Weight counts toward the total even when the sample misses the grid.
              total_nxt = ({1'b0, total_r} + (TW+1)'(in_weight) > (TW+1)'({TW{1'b1}}))
                          ? {TW{1'b1}} : total_r + TW'(in_weight);
              neg_nxt   = diff[32];
              mag_nxt   = diff[32] ? 32'(-diff) : diff[31:0];
              w_nxt     = in_weight;
            end
            wlb_pkg::FUNC_READ: begin
              bin_ok_nxt = (32'(in_bin_index) < 32'(NBINS));
            end
            default: ;
          endcase
        end
      end
      wlb_pkg::ST_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      wlb_pkg::ST_MUL: begin
        prod_nxt = mag_r * inv_bin_width_r;
      end
      wlb_pkg::ST_POS: begin
        if (neg_r) begin
          // Left of the grid: only bin 0 takes its share, and only within one bin.
          en_a_nxt  = 1'b0;
          en_b_nxt  = (q_neg <= 49'd65536);
          idx_b_nxt = '0;
          fac_b_nxt = 17'(49'd65536 - q_neg);
        end else begin
          en_a_nxt  = ({1'b0, ix} <= 33'(NBINS - 1));
          en_b_nxt  = ({1'b0, ix} <= 33'(NBINS - 2));
          idx_a_nxt = ix[AW-1:0];
          idx_b_nxt = ix[AW-1:0] + 1'b1;
          fac_b_nxt = {1'b0, fx};
        end
        fac_a_nxt = 17'h10000 - {1'b0, fx};
      end
      wlb_pkg::ST_AMT: begin
        amt_a_nxt = w_r * fac_a_r;
        amt_b_nxt = w_r * fac_b_r;
        mem_ra    = idx_a_r;
      end
      wlb_pkg::ST_WA: begin
        // The read of the second bin goes out while the first is written back;
        // the addresses differ whenever both bins are written, so no forwarding is needed.
        mem_we = en_a_r;
        mem_wa = idx_a_r;
        mem_wd = sat_add(rd_data_r, amt_a_r);
        mem_ra = idx_b_r;
      end
      wlb_pkg::ST_WB: begin
        mem_we = en_b_r;
        mem_wa = idx_b_r;
        mem_wd = sat_add(rd_data_r, amt_b_r);
      end
      wlb_pkg::ST_RLD: begin
        if (total_r == '0) begin
          out_valid_nxt     = 1'b1;
          out_density_nxt   = '0;
          out_no_weight_nxt = 1'b1;
        end else if (mass_rd >= {total_r, 16'h0000}) begin
          out_valid_nxt     = 1'b1;
          out_density_nxt   = '1;
          out_no_weight_nxt = 1'b0;
        end else begin
          rem_nxt     = mass_rd[MW-1:16];
          dvd_nxt     = {mass_rd[15:0], 16'h0000};
          quo_nxt     = '0;
          div_cnt_nxt = 5'd31;
        end
      end
      wlb_pkg::ST_DIV: begin
        rem_nxt     = div_bit ? TW'(div_trial - {1'b0, total_r}) : div_trial[TW-1:0];
        dvd_nxt     = {dvd_r[30:0], 1'b0};
        quo_nxt     = {quo_r[30:0], div_bit};
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          out_valid_nxt     = 1'b1;
          out_density_nxt   = {quo_r[30:0], div_bit};
          out_no_weight_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers; reset starts the clearing sweep of the bin memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= wlb_pkg::ST_CLR;
      clr_cnt_r       <= '0;
      div_cnt_r       <= '0;
      total_r         <= '0;
      out_valid_r     <= 1'b0;
      grid_low_r      <= '0;
      inv_bin_width_r <= 32'd65536;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (wlb_pkg::cfg_idx_t'(cfg_index))
          wlb_pkg::CFG_GRID_LOW:      grid_low_r      <= cfg_wdata;
          wlb_pkg::CFG_INV_BIN_WIDTH: inv_bin_width_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r           <= mag_nxt;
    neg_r           <= neg_nxt;
    w_r             <= w_nxt;
    prod_r          <= prod_nxt;
    en_a_r          <= en_a_nxt;
    en_b_r          <= en_b_nxt;
    idx_a_r         <= idx_a_nxt;
    idx_b_r         <= idx_b_nxt;
    fac_a_r         <= fac_a_nxt;
    fac_b_r         <= fac_b_nxt;
    amt_a_r         <= amt_a_nxt;
    amt_b_r         <= amt_b_nxt;
    bin_ok_r        <= bin_ok_nxt;
    rem_r           <= rem_nxt;
    dvd_r           <= dvd_nxt;
    quo_r           <= quo_nxt;
    out_density_r   <= out_density_nxt;
    out_no_weight_r <= out_no_weight_nxt;
  end

  // Bin memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= bin_mem[mem_ra];
  end

endmodule
